// ----- design/b64d_pkg.sv -----
package b64d_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
	localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

	typedef enum logic [1:0] {
		KIND_ALPHA,
		KIND_PAD,
		KIND_BAD
	} char_kind_t;

	// One classified character word as it travels from the front to the back.
	typedef struct packed {
		char_kind_t  kind;
		logic [5:0]  sextet;
		logic        last;
	} char_item_t;

	function automatic char_item_t classify(input logic [7:0] c, input logic last);
		char_item_t item;
		item.kind   = KIND_ALPHA;
		item.sextet = '0;
		item.last   = last;
		if (c >= 8'h41 && c <= 8'h5A) begin
			item.sextet = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			item.sextet = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			item.sextet = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2D) begin
			item.sextet = 6'd62;
		end else if (c == 8'h5F) begin
			item.sextet = 6'd63;
		end else if (c == PAD_CHAR) begin
			item.kind = KIND_PAD;
		end else begin
			item.kind = KIND_BAD;
		end
		return item;
	endfunction

endpackage

// ----- design/b64d_front.sv -----
module b64d_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             char_code,
	input  logic                   end_of_message,
	output logic                   push_valid,
	input  logic                   push_ready,
	output b64d_pkg::char_item_t   push_item
);

	logic                 valid_s1;
	b64d_pkg::char_item_t item_s1;
	logic                 accept;

	// The stage takes a new word whenever it is empty or its word moves on.
	assign in_ready   = !valid_s1 || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= b64d_pkg::classify(char_code, end_of_message);
		end
	end

endmodule

// ----- design/b64d_queue.sv -----
module b64d_queue #(
	parameter int unsigned Depth = b64d_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_ready,
	input  b64d_pkg::char_item_t   push_item,
	output logic                   pop_valid,
	input  logic                   pop,
	output b64d_pkg::char_item_t   pop_item
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	b64d_pkg::char_item_t entries_q [Depth];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != FullCnt);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FullCnt)
		else $error("queue fill count above its depth");

endmodule

// ----- design/b64d_back.sv -----
module b64d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   pop,
	input  b64d_pkg::char_item_t   item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             byte_out,
	output logic                   byte_ok,
	output logic                   message_done,
	output logic [1:0]             status
);

	logic [5:0] leftover_bits_q;
	logic [2:0] leftover_count_q;
	logic [1:0] length_mod_four_q;
	logic [1:0] pad_run_q;
	logic       pad_pending_q;
	logic       bad_q;

	logic       out_valid_q;
	logic [7:0] byte_out_q;
	logic       byte_ok_q;
	logic       done_q;
	logic [1:0] status_q;

	logic [5:0]  bits_n;
	logic [2:0]  count_n;
	logic [1:0]  len_n;
	logic [1:0]  run_n;
	logic        pending_n;
	logic        bad_n;
	logic [11:0] buf_w;
	logic [3:0]  cnt_w;
	logic [5:0]  mask_w;
	logic [7:0]  byte_w;
	logic        byte_ok_w;
	logic [1:0]  status_w;
	logic        has_result;

	// The output register frees up when empty or when its word is taken.
	assign pop = item_valid && (!out_valid_q || out_ready);

	always_comb begin
		bits_n    = leftover_bits_q;
		count_n   = leftover_count_q;
		len_n     = length_mod_four_q + 2'd1;
		run_n     = pad_run_q;
		pending_n = pad_pending_q;
		bad_n     = bad_q;
		buf_w     = {leftover_bits_q, item.sextet};
		cnt_w     = {1'b0, leftover_count_q} + 4'd6;
		mask_w    = '0;
		byte_w    = '0;
		byte_ok_w = 1'b0;
		status_w  = b64d_pkg::STATUS_OK;

		if (item.kind == b64d_pkg::KIND_PAD) begin
			pending_n = 1'b1;
			run_n     = pad_run_q + 2'd1;
		end else begin
			// A character after padding turns the padding into bad characters.
			if (pad_pending_q) begin
				bad_n     = 1'b1;
				pending_n = 1'b0;
				run_n     = '0;
			end
			if (item.kind == b64d_pkg::KIND_BAD) begin
				bad_n = 1'b1;
			end else begin
				if (cnt_w >= 4'd8) begin
					cnt_w     = cnt_w - 4'd8;
					byte_w    = 8'(buf_w >> cnt_w);
					byte_ok_w = 1'b1;
				end
				count_n = cnt_w[2:0];
				for (int i = 0; i < 6; i++) begin
					mask_w[i] = (3'(i) < count_n);
				end
				bits_n = buf_w[5:0] & mask_w;
			end
		end

		if (2'(len_n - run_n) == 2'd1) begin
			status_w = b64d_pkg::STATUS_BAD_LEN;
		end else if (bad_n) begin
			status_w = b64d_pkg::STATUS_BAD_CHAR;
		end
		has_result = byte_ok_w || item.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_bits_q   <= '0;
			leftover_count_q  <= '0;
			length_mod_four_q <= '0;
			pad_run_q         <= '0;
			pad_pending_q     <= 1'b0;
			bad_q             <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= has_result;
				if (item.last) begin
					leftover_bits_q   <= '0;
					leftover_count_q  <= '0;
					length_mod_four_q <= '0;
					pad_run_q         <= '0;
					pad_pending_q     <= 1'b0;
					bad_q             <= 1'b0;
				end else begin
					leftover_bits_q   <= bits_n;
					leftover_count_q  <= count_n;
					length_mod_four_q <= len_n;
					pad_run_q         <= run_n;
					pad_pending_q     <= pending_n;
					bad_q             <= bad_n;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_result) begin
			byte_out_q <= byte_w;
			byte_ok_q  <= byte_ok_w;
			done_q     <= item.last;
			status_q   <= item.last ? status_w : b64d_pkg::STATUS_OK;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_out     = byte_out_q;
	assign byte_ok      = byte_ok_q;
	assign message_done = done_q;
	assign status       = status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!leftover_count_q[0] && leftover_count_q <= 3'd6)
		else $error("leftover bit count is odd or above six");

	assert property (@(posedge clk) disable iff (!arst_n)
		!pad_pending_q |-> pad_run_q == '0)
		else $error("padding run counted without pending padding");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop && item.last |=> length_mod_four_q == '0 && !bad_q && !pad_pending_q
			&& leftover_count_q == '0)
		else $error("message state not cleared after the final word");

endmodule

// ----- design/base64url_stream_decoder.sv -----
// Channel | Handshake            | Payload
// in      | in_valid, in_ready   | char_code, end_of_message
// out     | out_valid, out_ready | byte_out, byte_ok, message_done, status
//
// One character word is taken per cycle while out_ready stays high.
// A word passes the classify stage, the queue and the decode register, in that order.
// Reset clears the stream state, the queue and both valid flags at once.
// A stall at the output fills the queue and then the classify stage,
// after which in_ready falls; no word is lost or repeated.
module base64url_stream_decoder #(
	parameter int unsigned QueueDepth = b64d_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic       byte_ok,
	output logic       message_done,
	output logic [1:0] status
);

	logic                 push_valid;
	logic                 push_ready;
	b64d_pkg::char_item_t push_item;
	logic                 pop_valid;
	logic                 pop;
	b64d_pkg::char_item_t pop_item;

	b64d_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_code      (char_code),
		.end_of_message (end_of_message),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	b64d_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (pop_valid),
		.pop          (pop),
		.item         (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_out     (byte_out),
		.byte_ok      (byte_ok),
		.message_done (message_done),
		.status       (status)
	);

endmodule

// ----- test/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned SETTLE_WAIT  = 12;
	localparam int unsigned PHASE_WORDS  = 420;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       byte_ok;
		logic       message_done;
		logic [1:0] status;
	} decode_result_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
		bit         drain;
	} char_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = '0;
	logic       end_of_message = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] byte_out;
	logic       byte_ok;
	logic       message_done;
	logic [1:0] status;

	char_word_t     char_words[$];
	decode_result_t expected_results[$];
	int unsigned    words_queued = 0;
	int unsigned    words_accepted = 0;
	int unsigned    send_idle_pct = 0;
	int unsigned    recv_idle_pct = 0;
	int unsigned    error_count = 0;
	int unsigned    cycle_count = 0;

	// Stream state of the decoder as the predictor sees it.
	logic [5:0] carry_bits = '0;
	logic [2:0] carry_count = '0;
	logic [1:0] length_mod4 = '0;
	logic [1:0] pad_run = '0;
	logic       pad_seen = 1'b0;
	logic       bad_seen = 1'b0;

	base64url_stream_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_code     (char_code),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.byte_out      (byte_out),
		.byte_ok       (byte_ok),
		.message_done  (message_done),
		.status        (status)
	);

	always #5 clk = ~clk;

	// Bit 6 set means the character is outside the alphabet.
	function automatic logic [6:0] sextet_value(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
		if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
		if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
		if (c == 8'h2D) return 7'd62;
		if (c == 8'h5F) return 7'd63;
		return 7'd64;
	endfunction

	function automatic logic [7:0] alphabet_char(input int unsigned idx);
		if (idx < 26) return 8'(8'h41 + idx);
		if (idx < 52) return 8'(8'h61 + idx - 26);
		if (idx < 62) return 8'(8'h30 + idx - 52);
		if (idx == 62) return 8'h2D;
		return 8'h5F;
	endfunction

	task automatic decode_word(input logic [7:0] c, input logic last);
		logic [6:0]     sym;
		logic [11:0]    bit_buf;
		logic [3:0]     bit_count;
		decode_result_t res;
		res = '0;
		length_mod4 = length_mod4 + 2'd1;
		if (c == b64d_pkg::PAD_CHAR) begin
			pad_seen = 1'b1;
			pad_run = pad_run + 2'd1;
		end else begin
			sym = sextet_value(c);
			if (pad_seen) begin
				// Text after padding: the whole message is bad and the run no longer trails.
				bad_seen = 1'b1;
				pad_seen = 1'b0;
				pad_run = '0;
			end
			if (sym[6]) begin
				bad_seen = 1'b1;
			end else begin
				bit_buf = {carry_bits, sym[5:0]};
				bit_count = 4'(carry_count) + 4'd6;
				if (bit_count >= 4'd8) begin
					bit_count = bit_count - 4'd8;
					res.byte_out = 8'(bit_buf >> bit_count);
					res.byte_ok = 1'b1;
				end
				carry_count = bit_count[2:0];
				carry_bits = 6'(bit_buf & ((12'd1 << bit_count) - 12'd1));
			end
		end
		if (last) begin
			res.message_done = 1'b1;
			if (2'(length_mod4 - pad_run) == 2'd1) begin
				res.status = b64d_pkg::STATUS_BAD_LEN;
			end else if (bad_seen) begin
				res.status = b64d_pkg::STATUS_BAD_CHAR;
			end else begin
				res.status = b64d_pkg::STATUS_OK;
			end
			carry_bits = '0;
			carry_count = '0;
			length_mod4 = '0;
			pad_run = '0;
			pad_seen = 1'b0;
			bad_seen = 1'b0;
		end
		if (res.byte_ok || last) expected_results = {expected_results, res};
	endtask

	task automatic push_word(input logic [7:0] c, input logic last, input bit drain);
		char_word_t w;
		w.code = c;
		w.last = last;
		w.drain = drain;
		char_words = {char_words, w};
		words_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1, 1'b0);
	endtask

	// Text length with the given remainder mod 4, never empty.
	function automatic int unsigned text_length(input int unsigned rem);
		int unsigned len;
		len = 4 * $urandom_range(3) + rem;
		if (len == 0) len = 4;
		return len;
	endfunction

	task automatic add_random_message(input bit drain);
		logic [7:0]  text[$];
		int unsigned pick;
		int unsigned len;
		int unsigned pad_len;
		int unsigned pos;
		int unsigned hit;
		pick = $urandom_range(99);
		pad_len = 0;
		pos = 0;
		hit = 0;
		if (pick < 75) begin
			if (pick < 65) begin
				case ($urandom_range(2))
					0: len = text_length(2);
					1: len = text_length(3);
					default: len = text_length(0);
				endcase
			end else begin
				len = text_length(1);
			end
			if ($urandom_range(1) == 1 && len % 4 != 0) pad_len = 4 - len % 4;
			else if ($urandom_range(3) == 0) pad_len = $urandom_range(1, 5);
			for (int i = 0; i < len; i++) text = {text, alphabet_char($urandom_range(63))};
		end else if (pick < 85) begin
			// Padding in the middle of otherwise valid text.
			len = text_length($urandom_range(3));
			if (len < 2) len = 2;
			pos = $urandom_range(1, len - 1);
			for (int i = 0; i < len; i++) begin
				if (i == pos) begin
					hit = $urandom_range(1, 3);
					for (int j = 0; j < hit; j++) text = {text, b64d_pkg::PAD_CHAR};
				end
				text = {text, alphabet_char($urandom_range(63))};
			end
			if ($urandom_range(1) == 1) pad_len = $urandom_range(1, 3);
		end else if (pick < 95) begin
			// One character replaced by an arbitrary byte.
			len = text_length($urandom_range(3));
			pos = $urandom_range(len - 1);
			for (int i = 0; i < len; i++) begin
				if (i == pos) text = {text, 8'($urandom_range(255))};
				else text = {text, alphabet_char($urandom_range(63))};
			end
		end else if (pick < 98) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) text = {text, 8'($urandom_range(255))};
		end else begin
			pad_len = $urandom_range(1, 4);
		end
		for (int i = 0; i < pad_len; i++) text = {text, b64d_pkg::PAD_CHAR};
		for (int i = 0; i < text.size(); i++) begin
			push_word(text[i], i == text.size() - 1, drain && i == 0);
		end
	endtask

	task automatic add_random_phase(input int unsigned word_count);
		int unsigned start;
		start = words_queued;
		add_random_message(1'b1);
		while (words_queued - start < word_count) add_random_message($urandom_range(99) == 0);
	endtask

	task automatic wait_words_sent();
		while (char_words.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		char_word_t pending_word;
		logic       fire;
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= '0;
			end_of_message <= 1'b0;
		end else begin
			fire = in_valid && in_ready;
			if (fire) begin
				decode_word(char_code, end_of_message);
				words_accepted++;
			end
			if (!in_valid || fire) begin
				if (char_words.size() != 0 &&
				    !(char_words[0].drain && expected_results.size() != 0) &&
				    $urandom_range(99) >= send_idle_pct) begin
					pending_word = char_words.pop_front();
					in_valid <= 1'b1;
					char_code <= pending_word.code;
					end_of_message <= pending_word.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		decode_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: byte_out %0h byte_ok %0b message_done %0b status %0d",
					       byte_out, byte_ok, message_done, status);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (byte_out !== want.byte_out) begin
						$error("byte_out: expected %0h, got %0h", want.byte_out, byte_out);
						error_count++;
					end
					if (byte_ok !== want.byte_ok) begin
						$error("byte_ok: expected %0b, got %0b", want.byte_ok, byte_ok);
						error_count++;
					end
					if (message_done !== want.message_done) begin
						$error("message_done: expected %0b, got %0b", want.message_done,
						       message_done);
						error_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						error_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		send_idle_pct = 25;
		recv_idle_pct = 74;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_text("TWFu");
		push_text("QQ==");
		push_text("_-9z");
		push_text("A");
		push_text("Q=Q");
		push_word(8'h41, 1'b0, 1'b0);
		push_word(8'h42, 1'b0, 1'b0);
		push_word(8'h00, 1'b1, 1'b0);
		push_word(8'hFF, 1'b1, 1'b0);
		push_text("==");
		add_random_phase(PHASE_WORDS - 22);
		wait_words_sent();

		send_idle_pct = 74;
		recv_idle_pct = 25;
		add_random_phase(PHASE_WORDS);
		wait_words_sent();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_phase(PHASE_WORDS);

		while (words_accepted != words_queued) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
